### hdl/gmds_pkg.sv
// shared constants, types and helpers for the grid maze depth-first solver
`timescale 1ns / 1ps
`default_nettype none
package gmds_pkg;

  typedef logic [2:0] mark_t;
  typedef logic [1:0] cmd_t;

  localparam mark_t MARK_OPEN = 3'd0;
  localparam mark_t MARK_WALL = 3'd1;
  localparam mark_t MARK_GOAL = 3'd2;
  localparam mark_t MARK_PATH = 3'd3;
  localparam mark_t MARK_DEAD = 3'd4;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_SOLVE = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;
  localparam int VALUE_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  function automatic logic enterable(input mark_t m);
    enterable = (m == MARK_OPEN) || (m == MARK_GOAL);
  endfunction

endpackage
`default_nettype wire

### hdl/gmds_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gmds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/grid_maze_dfs_solver_core.sv
// top level of the grid maze depth-first solver (south and east moves only)
`timescale 1ns / 1ps
`default_nettype none
// Cells are loaded one per item (command 0) into a mark ram addressed by {row, column};
// command 2 reads a mark back, command 1 runs a stack-based depth-first search from the
// top-left cell toward the goal, moving south or east only and trying east first. Every
// item gives exactly one result. A load, an unknown command or a read outside the grid in
// use is answered straight from the idle state; a read inside the grid first waits in a
// read-data state for the registered mark ram. A solve seeds the stack with the top-left
// cell, then runs search steps, where one step examines the top of the stack: the TOP and
// IDX states cover the registered stack ram read, then three reads of the single mark ram
// port (current cell, south, east) follow; a step that finds the goal ends after the
// current-cell read. A cell extends at most once and is pushed at most twice. The input is
// not ready while an item is in progress; a finished result waits in the output register
// and the next item is taken as soon as that register is free or being emptied. Cells that
// were never loaded read back as undefined and must not be read or solved over.
module grid_maze_dfs_solver_core
  import gmds_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [15:0]       in_tdata,   // cell_row, cell_column, cell_value, zero pad
  input  wire  [1:0]        in_tuser,   // command
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [7:0]        out_tdata,  // solved, cell_mark, zero pad
  input  wire               cfg_we,
  input  wire               cfg_addr,
  input  wire  [CFG_W-1:0]  cfg_wdata
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int AW    = RW + CW;
  localparam int CELLS = 1 << AW;
  localparam int SD    = 2 * MAX_ROWS * MAX_COLUMNS + 1;
  localparam int SAW   = $clog2(SD);
  localparam int DCW   = $clog2(SD + 1);
  localparam int RLW   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam int CLW   = ($clog2(MAX_COLUMNS + 1) > CFG_W) ? $clog2(MAX_COLUMNS + 1) : CFG_W;

  localparam logic [VALUE_W-1:0] VAL_BAD = 2'd3;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDATA = 3'd1;
  localparam logic [2:0] ST_TOP   = 3'd2;
  localparam logic [2:0] ST_IDX   = 3'd3;
  localparam logic [2:0] ST_CUR   = 3'd4;
  localparam logic [2:0] ST_SOUTH = 3'd5;
  localparam logic [2:0] ST_EAST  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [DCW-1:0]   depth_r, depth_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             grew_r, grew_nxt;
  logic [CFG_W-1:0] rows_r, cols_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_solved_r, out_solved_nxt;
  mark_t            out_mark_r, out_mark_nxt;

  logic [RLW-1:0]   rows_use, row_ext, cur_row_ext;
  logic [CLW-1:0]   cols_use, col_ext, cur_col_ext;
  logic             in_grid, accept, push_room;
  cmd_t             in_cmd;
  logic [AW-1:0]    in_addr, south_addr, east_addr;
  logic [RW-1:0]    cur_row;
  logic [CW-1:0]    cur_col;
  logic             south_ok, east_ok, south_push, east_fit, grew_all;

  logic             mark_we;
  logic [AW-1:0]    mark_waddr, mark_raddr;
  mark_t            mark_wdata, mark_rdata;
  logic             stk_we;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [AW-1:0]    stk_wdata, stk_rdata;

  gmds_ram #(.WIDTH(3), .DEPTH(CELLS)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  gmds_ram #(.WIDTH(AW), .DEPTH(SD)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // grid size in use, clamped to 1..max
  always_comb begin
    if (rows_r == '0) begin
      rows_use = RLW'(1);
    end else if (RLW'(rows_r) > RLW'(MAX_ROWS)) begin
      rows_use = RLW'(MAX_ROWS);
    end else begin
      rows_use = RLW'(rows_r);
    end
    if (cols_r == '0) begin
      cols_use = CLW'(1);
    end else if (CLW'(cols_r) > CLW'(MAX_COLUMNS)) begin
      cols_use = CLW'(MAX_COLUMNS);
    end else begin
      cols_use = CLW'(cols_r);
    end
  end

  assign in_cmd  = in_tuser;
  assign row_ext = RLW'(in_tdata[COORD_W-1:0]);
  assign col_ext = CLW'(in_tdata[2*COORD_W-1:COORD_W]);
  assign in_grid = (row_ext < rows_use) && (col_ext < cols_use);
  assign in_addr = {row_ext[RW-1:0], col_ext[CW-1:0]};

  assign cur_row     = idx_r[AW-1:CW];
  assign cur_col     = idx_r[CW-1:0];
  assign cur_row_ext = RLW'(cur_row) + RLW'(1);
  assign cur_col_ext = CLW'(cur_col) + CLW'(1);
  assign south_ok    = cur_row_ext < rows_use;
  assign east_ok     = cur_col_ext < cols_use;
  assign south_addr  = {cur_row + RW'(1), cur_col};
  assign east_addr   = {cur_row, cur_col + CW'(1)};
  assign push_room   = depth_r < DCW'(SD);
  assign south_push  = south_ok && enterable(mark_rdata);
  assign east_fit    = east_ok && enterable(mark_rdata);
  assign grew_all    = grew_r || east_fit;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    idx_nxt        = idx_r;
    grew_nxt       = grew_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_solved_nxt = out_solved_r;
    out_mark_nxt   = out_mark_r;
    mark_we        = 1'b0;
    mark_waddr     = in_addr;
    mark_wdata     = mark_t'(in_tdata[2*COORD_W+VALUE_W-1:2*COORD_W]);
    mark_raddr     = in_addr;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[SAW-1:0];
    stk_wdata      = south_addr;
    stk_raddr      = SAW'(depth_r - DCW'(1));
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_solved_nxt = 1'b0;
          out_mark_nxt   = MARK_OPEN;
          case (in_cmd)
            CMD_LOAD: begin
              mark_we       = in_grid &&
                              (in_tdata[2*COORD_W+VALUE_W-1:2*COORD_W] != VAL_BAD);
              out_valid_nxt = 1'b1;
            end
            CMD_SOLVE: begin
              mark_we    = 1'b1;
              mark_waddr = '0;
              mark_wdata = MARK_PATH;
              stk_we     = 1'b1;
              stk_waddr  = '0;
              stk_wdata  = '0;
              depth_nxt  = DCW'(1);
              state_nxt  = ST_TOP;
            end
            CMD_READ: begin
              if (in_grid) begin
                state_nxt = ST_RDATA;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RDATA: begin
        out_mark_nxt  = mark_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_TOP: begin
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        idx_nxt    = stk_rdata;
        mark_raddr = stk_rdata;
        state_nxt  = ST_CUR;
      end
      ST_CUR: begin
        mark_raddr = south_addr;
        grew_nxt   = 1'b0;
        if (mark_rdata == MARK_GOAL) begin
          out_solved_nxt = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_SOUTH;
        end
      end
      ST_SOUTH: begin
        mark_raddr = east_addr;
        if (south_push) begin
          grew_nxt = 1'b1;
          if (push_room) begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + DCW'(1);
          end
        end
        state_nxt = ST_EAST;
      end
      ST_EAST: begin
        stk_wdata  = east_addr;
        mark_we    = 1'b1;
        mark_waddr = idx_r;
        state_nxt  = ST_TOP;
        if (grew_all) begin
          mark_wdata = MARK_PATH;
          if (east_fit && push_room) begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + DCW'(1);
          end
        end else begin
          mark_wdata = MARK_DEAD;
          depth_nxt  = depth_r - DCW'(1);
          if (depth_r == DCW'(1)) begin
            out_solved_nxt = 1'b0;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      grew_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= CFG_RESET;
      cols_r      <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      grew_r      <= grew_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ROW_COUNT:    rows_r <= cfg_wdata;
          CFG_COLUMN_COUNT: cols_r <= cfg_wdata;
          default:          rows_r <= rows_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_solved_r <= out_solved_nxt;
    out_mark_r   <= out_mark_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_mark_r, out_solved_r};

endmodule
`default_nettype wire

### sim/tb_grid_maze_dfs_solver_core.sv
// self-checking testbench for the grid maze solver core: directed table, then random mazes
`timescale 1ns / 1ps
module tb_grid_maze_dfs_solver_core;
  import gmds_pkg::*;

  localparam cmd_t CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] VAL_OPEN = 2'd0;
  localparam logic [1:0] VAL_WALL = 2'd1;
  localparam logic [1:0] VAL_GOAL = 2'd2;
  localparam logic [1:0] VAL_BAD  = 2'd3;
  localparam int GRID_MAX        = 64;
  localparam int STACK_DEPTH_MAX = 2 * GRID_MAX * GRID_MAX + 1;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;

  typedef struct packed {
    logic  solved;
    mark_t mark;
  } maze_result_t;

  typedef struct packed {
    logic       is_cfg;
    logic       reg_index;
    logic [6:0] reg_value;
    cmd_t       cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] val;
    logic       typed;
    logic       want_solved;
    mark_t      want_mark;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // cell_row, cell_column, cell_value, zero pad
  logic [1:0]        in_tuser;   // command
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // solved, cell_mark, zero pad
  logic              cfg_we;
  logic              cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;

  mark_t        maze_marks [0:GRID_MAX*GRID_MAX-1];
  logic [11:0]  path_stack [0:STACK_DEPTH_MAX-1];
  int           stack_top;
  logic [6:0]   row_reg;
  logic [6:0]   col_reg;

  maze_result_t pending_results [$];
  step_t        plan [$];
  maze_result_t seen_want;
  int burst_left;
  int error_count;
  int results_seen;
  int items_sent;
  int solve_count;
  int goal_count;
  int grid_count;
  int rand_items;
  int cycle_count;

  always #5 clk = ~clk;

  grid_maze_dfs_solver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic int clamp_size(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'd64) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic void push_cell(input logic [11:0] at);
    if (stack_top < STACK_DEPTH_MAX) begin
      path_stack[stack_top] = at;
      stack_top++;
    end
  endfunction

  function automatic logic search_maze();
    int rows;
    int cols;
    int r;
    int c;
    logic [11:0] here;
    logic grew;
    mark_t m;
    rows = clamp_size(row_reg);
    cols = clamp_size(col_reg);
    stack_top = 0;
    maze_marks[0] = MARK_PATH;
    push_cell(12'd0);
    while (stack_top > 0) begin
      here = path_stack[stack_top-1];
      r = int'(here[11:6]);
      c = int'(here[5:0]);
      grew = 1'b0;
      if (maze_marks[here] == MARK_GOAL) return 1'b1;
      if (r + 1 < rows) begin
        m = maze_marks[here + 12'd64];
        if (m == MARK_OPEN || m == MARK_GOAL) begin
          push_cell(here + 12'd64);
          grew = 1'b1;
        end
      end
      if (c + 1 < cols) begin
        m = maze_marks[here + 12'd1];
        if (m == MARK_OPEN || m == MARK_GOAL) begin
          push_cell(here + 12'd1);
          grew = 1'b1;
        end
      end
      if (grew) begin
        maze_marks[here] = MARK_PATH;
      end else begin
        maze_marks[here] = MARK_DEAD;
        stack_top--;
      end
    end
    return 1'b0;
  endfunction

  function automatic maze_result_t predict_item(input cmd_t cmd, input logic [5:0] row,
                                                input logic [5:0] col, input logic [1:0] val);
    maze_result_t res;
    logic in_grid;
    logic [11:0] at;
    res = '0;
    in_grid = int'(row) < clamp_size(row_reg) && int'(col) < clamp_size(col_reg);
    at = {row, col};
    case (cmd)
      CMD_LOAD: begin
        if (in_grid && val != VAL_BAD) maze_marks[at] = {1'b0, val};
      end
      CMD_SOLVE: begin
        res.solved = search_maze();
      end
      CMD_READ: begin
        if (in_grid) res.mark = maze_marks[at];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic step_t item_step(input cmd_t cmd, input logic [5:0] row,
                                      input logic [5:0] col, input logic [1:0] val,
                                      input logic typed, input logic want_solved,
                                      input mark_t want_mark);
    step_t s;
    s = '0;
    s.cmd = cmd;
    s.row = row;
    s.col = col;
    s.val = val;
    s.typed = typed;
    s.want_solved = want_solved;
    s.want_mark = want_mark;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic reg_index, input logic [6:0] reg_value);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_index = reg_index;
    s.reg_value = reg_value;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
  endtask

  task automatic send_item(input cmd_t cmd, input logic [5:0] row, input logic [5:0] col,
                           input logic [1:0] val, input logic use_fixed,
                           input maze_result_t fixed);
    int gap;
    maze_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, val, col, row};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    want = predict_item(cmd, row, col, val);
    items_sent++;
    if (cmd == CMD_SOLVE) begin
      solve_count++;
      if (want.solved) goal_count++;
    end
    if (use_fixed) want = fixed;
    pending_results.push_back(want);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [6:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_COUNT) row_reg = v;
    else col_reg = v;
  endtask

  task automatic outside_cell(input int rows, input int cols,
                              output logic [5:0] row, output logic [5:0] col);
    row = 6'($urandom);
    col = 6'($urandom);
    if (rows < GRID_MAX && (cols == GRID_MAX || $urandom_range(0, 1) == 1))
      row = 6'($urandom_range(rows, GRID_MAX - 1));
    else
      col = 6'($urandom_range(cols, GRID_MAX - 1));
  endtask

  // items the block ignores or answers with zeros
  task automatic send_noise(input int rows, input int cols);
    logic [5:0] row;
    logic [5:0] col;
    maze_result_t none;
    none = '0;
    outside_cell(rows, cols, row, col);
    case ($urandom_range(0, 3))
      0: send_item(CMD_UNKNOWN, 6'($urandom), 6'($urandom), 2'($urandom), 1'b0, none);
      1: send_item(CMD_LOAD, row, col, 2'($urandom), 1'b0, none);
      2: send_item(CMD_LOAD, 6'($urandom_range(0, rows - 1)),
                   6'($urandom_range(0, cols - 1)), VAL_BAD, 1'b0, none);
      default: send_item(CMD_READ, row, col, 2'($urandom), 1'b0, none);
    endcase
  endtask

  // one maze: pick a size, load every cell, then solves, reads and edits
  task automatic run_maze();
    int pick;
    int rows;
    int cols;
    int goal_r;
    int goal_c;
    int tail;
    int r;
    int c;
    int k;
    logic [6:0] rows_raw;
    logic [6:0] cols_raw;
    logic [1:0] v;
    maze_result_t none;
    none = '0;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      rows_raw = 7'($urandom_range(64, 127));
      cols_raw = 7'($urandom_range(0, 1));
    end else if (pick == 1) begin
      rows_raw = 7'($urandom_range(0, 1));
      cols_raw = 7'($urandom_range(64, 127));
    end else begin
      rows_raw = 7'($urandom_range(1, 7));
      cols_raw = 7'($urandom_range(1, 7));
    end
    drain();
    write_register(CFG_ROW_COUNT, rows_raw);
    write_register(CFG_COLUMN_COUNT, cols_raw);
    grid_count++;
    rows = clamp_size(rows_raw);
    cols = clamp_size(cols_raw);
    goal_r = -1;
    goal_c = -1;
    if ($urandom_range(0, 3) != 0) begin
      goal_r = $urandom_range(0, rows - 1);
      goal_c = $urandom_range(0, cols - 1);
    end
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        if ($urandom_range(0, 7) == 0) send_noise(rows, cols);
        if (r == goal_r && c == goal_c) v = VAL_GOAL;
        else if ($urandom_range(0, 99) < 28) v = VAL_WALL;
        else v = VAL_OPEN;
        send_item(CMD_LOAD, 6'(r), 6'(c), v, 1'b0, none);
        rand_items++;
      end
    end
    tail = $urandom_range(4, 10);
    for (k = 0; k < tail; k++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        send_item(CMD_SOLVE, 6'($urandom), 6'($urandom), 2'($urandom), 1'b0, none);
        rand_items++;
      end else if (pick <= 5) begin
        send_item(CMD_READ, 6'($urandom_range(0, rows - 1)), 6'($urandom_range(0, cols - 1)),
                  2'($urandom), 1'b0, none);
        rand_items++;
      end else if (pick == 6) begin
        send_item(CMD_LOAD, 6'($urandom_range(0, rows - 1)), 6'($urandom_range(0, cols - 1)),
                  2'($urandom_range(0, 2)), 1'b0, none);
        rand_items++;
      end else begin
        send_noise(rows, cols);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, solved", int'(out_tdata[0]), 0);
      end else begin
        seen_want = pending_results.pop_front();
        if (out_tdata[0] !== seen_want.solved)
          report_mismatch("solved", int'(out_tdata[0]), int'(seen_want.solved));
        if (out_tdata[3:1] !== seen_want.mark)
          report_mismatch("cell_mark", int'(out_tdata[3:1]), int'(seen_want.mark));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("** grid_maze_dfs_solver_core: FAILED **");
      $finish;
    end
  end

  // receiver: changing stall modes, plus one long hold-off
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    bit held_once;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held_once = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= 15) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    maze_result_t fixed;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = 1'b0;
    cfg_wdata   = '0;
    cycle_count = 0;
    error_count = 0;
    results_seen = 0;
    items_sent  = 0;
    solve_count = 0;
    goal_count  = 0;
    grid_count  = 1;
    rand_items  = 0;
    burst_left  = 0;
    stack_top   = 0;
    row_reg     = CFG_RESET;
    col_reg     = CFG_RESET;
    foreach (maze_marks[i]) maze_marks[i] = MARK_OPEN;

    // full 64 x 64 grid after reset
    plan.push_back(item_step(CMD_LOAD, 6'd0, 6'd1, VAL_WALL, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_LOAD, 6'd1, 6'd0, VAL_WALL, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_LOAD, 6'd0, 6'd0, VAL_GOAL, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_GOAL));
    // goal on the start cell is overwritten and not found
    plan.push_back(item_step(CMD_SOLVE, 6'd0, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_DEAD));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd1, VAL_OPEN, 1'b1, 1'b0, MARK_WALL));
    plan.push_back(item_step(CMD_LOAD, 6'd63, 6'd63, VAL_GOAL, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_LOAD, 6'd63, 6'd63, VAL_BAD, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd63, 6'd63, VAL_OPEN, 1'b1, 1'b0, MARK_GOAL));
    plan.push_back(item_step(CMD_UNKNOWN, 6'd63, 6'd63, VAL_BAD, 1'b1, 1'b0, MARK_OPEN));
    // zero rows act as one, oversized columns as the maximum
    plan.push_back(cfg_step(CFG_ROW_COUNT, 7'd0));
    plan.push_back(cfg_step(CFG_COLUMN_COUNT, 7'd127));
    plan.push_back(item_step(CMD_LOAD, 6'd1, 6'd5, VAL_GOAL, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd1, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_LOAD, 6'd0, 6'd1, VAL_OPEN, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_LOAD, 6'd0, 6'd2, VAL_GOAL, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_SOLVE, 6'd0, 6'd0, VAL_OPEN, 1'b0, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd1, VAL_OPEN, 1'b1, 1'b0, MARK_PATH));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd2, VAL_OPEN, 1'b1, 1'b0, MARK_GOAL));
    // second solve sees the old path and gives up
    plan.push_back(item_step(CMD_SOLVE, 6'd0, 6'd0, VAL_OPEN, 1'b0, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_DEAD));
    plan.push_back(cfg_step(CFG_ROW_COUNT, 7'd127));
    plan.push_back(cfg_step(CFG_COLUMN_COUNT, 7'd0));
    plan.push_back(item_step(CMD_LOAD, 6'd5, 6'd1, VAL_OPEN, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd0, 6'd1, VAL_OPEN, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_SOLVE, 6'd0, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_OPEN));
    plan.push_back(item_step(CMD_READ, 6'd1, 6'd0, VAL_OPEN, 1'b1, 1'b0, MARK_WALL));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_register(plan[i].reg_index, plan[i].reg_value);
        grid_count++;
      end else begin
        fixed.solved = plan[i].want_solved;
        fixed.mark   = plan[i].want_mark;
        send_item(plan[i].cmd, plan[i].row, plan[i].col, plan[i].val, plan[i].typed, fixed);
      end
    end

    while (rand_items < 100) run_maze();

    drain();
    repeat (64) @(posedge clk);
    $display("run covered %0d items over %0d grid settings, %0d solves of which %0d hit a goal",
             items_sent, grid_count, solve_count, goal_count);
    $display("%0d results checked, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("** grid_maze_dfs_solver_core: PASSED **");
    end else begin
      $display("** grid_maze_dfs_solver_core: FAILED **");
    end
    $finish;
  end

endmodule
